FILE: rtl/clp_pkg.sv
// Shared constants, types and helpers for the CONNECT request line parser.
`timescale 1ns / 1ps
`default_nettype none

package clp_pkg;

    localparam int unsigned BYTE_W   = 8;
    localparam int unsigned FIELD_W  = 12;
    localparam int unsigned STATUS_W = 2;
    localparam int unsigned S_TDATA_W = 8;
    localparam int unsigned M_TDATA_W = 56;

    localparam logic [STATUS_W-1:0] ST_OK        = 2'd0;
    localparam logic [STATUS_W-1:0] ST_MALFORMED = 2'd1;
    localparam logic [STATUS_W-1:0] ST_TOO_LONG  = 2'd2;

    localparam logic [BYTE_W-1:0] CH_TAB   = 8'h09;
    localparam logic [BYTE_W-1:0] CH_LF    = 8'h0A;
    localparam logic [BYTE_W-1:0] CH_CR    = 8'h0D;
    localparam logic [BYTE_W-1:0] CH_SPACE = 8'h20;
    localparam logic [BYTE_W-1:0] CH_COLON = 8'h3A;
    localparam logic [BYTE_W-1:0] CH_LBRK  = 8'h5B;
    localparam logic [BYTE_W-1:0] CH_RBRK  = 8'h5D;

    // end-of-request flags handed from the parser to the verdict stage
    typedef struct packed {
        logic is_long;
        logic is_done;
        logic text_seen;
        logic bracket_mode;
        logic close_seen;
        logic colon_seen;
    } snap_flags_t;

    // "CONNECT " one character per match index
    function automatic logic [BYTE_W-1:0] method_char(input logic [2:0] idx);
        logic [BYTE_W-1:0] c;
        case (idx)
            3'd0:    c = 8'h43;
            3'd1:    c = 8'h4F;
            3'd2:    c = 8'h4E;
            3'd3:    c = 8'h4E;
            3'd4:    c = 8'h45;
            3'd5:    c = 8'h43;
            3'd6:    c = 8'h54;
            default: c = CH_SPACE;
        endcase
        return c;
    endfunction

    // space, tab, LF, VT, FF, CR
    function automatic logic is_space(input logic [BYTE_W-1:0] b);
        return (b == CH_SPACE) || ((b >= CH_TAB) && (b <= CH_CR));
    endfunction

endpackage

`default_nettype wire

FILE: rtl/clp_parser.sv
// Byte-wise request line parser: phase machine and position registers.
`timescale 1ns / 1ps
`default_nettype none

module clp_parser
    import clp_pkg::*;
#(
    parameter int unsigned MAX_LEN = 4096,
    parameter int unsigned PW      = 13
) (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              step,
    input  wire logic [BYTE_W-1:0] data_byte,
    input  wire logic              end_of_request,
    output logic                   snap_valid,
    output snap_flags_t            snap_flags,
    output logic [PW-1:0]          first_pos,
    output logic [PW-1:0]          end_pos,
    output logic [PW-1:0]          close_pos,
    output logic [PW-1:0]          colon_pos
);

    typedef enum logic [2:0] {
        PH_METHOD,
        PH_AUTH,
        PH_AFTER,
        PH_DONE,
        PH_REJECT,
        PH_LONG
    } phase_t;

    localparam logic [PW-1:0] LIMIT = PW'(MAX_LEN);
    localparam logic [PW-1:0] ONE   = PW'(1);

    phase_t        phase_reg, phase_next;
    logic [PW-1:0] pos_reg, pos_next;
    logic [2:0]    midx_reg, midx_next;
    logic          prev_cr_reg, prev_cr_next;
    logic [PW-1:0] first_reg, first_next;
    logic [PW-1:0] end_reg, end_next;
    logic          text_seen_reg, text_seen_next;
    logic          bracket_reg, bracket_next;
    logic [PW-1:0] close_reg, close_next;
    logic          close_seen_reg, close_seen_next;
    logic [PW-1:0] colon_reg, colon_next;
    logic          colon_seen_reg, colon_seen_next;
    logic [PW:0]   close_plus1;

    assign close_plus1 = {1'b0, close_reg} + {1'b0, ONE};

    always_comb
    begin
        phase_next      = phase_reg;
        pos_next        = pos_reg;
        midx_next       = midx_reg;
        first_next      = first_reg;
        end_next        = end_reg;
        text_seen_next  = text_seen_reg;
        bracket_next    = bracket_reg;
        close_next      = close_reg;
        close_seen_next = close_seen_reg;
        colon_next      = colon_reg;
        colon_seen_next = colon_seen_reg;
        prev_cr_next    = (data_byte == CH_CR);

        if (phase_reg != PH_LONG && pos_reg >= LIMIT)
        begin
            phase_next = PH_LONG;
        end
        else if (phase_reg != PH_LONG)
        begin
            if (prev_cr_reg && data_byte == CH_LF &&
                (phase_reg == PH_METHOD || phase_reg == PH_AUTH || phase_reg == PH_AFTER))
            begin
                phase_next = (phase_reg == PH_AFTER) ? PH_DONE : PH_REJECT;
            end
            else
            begin
                case (phase_reg)
                    PH_METHOD:
                    begin
                        if (data_byte == method_char(midx_reg))
                        begin
                            midx_next = midx_reg + 3'd1;
                            if (midx_reg == 3'd7)
                                phase_next = PH_AUTH;
                        end
                        else
                        begin
                            phase_next = PH_REJECT;
                        end
                    end
                    PH_AUTH:
                    begin
                        if (data_byte == CH_SPACE)
                        begin
                            phase_next = PH_AFTER;
                        end
                        else if (!is_space(data_byte))
                        begin
                            if (!text_seen_reg)
                            begin
                                text_seen_next = 1'b1;
                                first_next     = pos_reg;
                                bracket_next   = (data_byte == CH_LBRK);
                                if (data_byte == CH_COLON)
                                begin
                                    colon_seen_next = 1'b1;
                                    colon_next      = pos_reg;
                                end
                            end
                            else if (bracket_reg)
                            begin
                                if (data_byte == CH_RBRK && !close_seen_reg)
                                begin
                                    close_seen_next = 1'b1;
                                    close_next      = pos_reg;
                                end
                                // port colon only directly after the closing bracket
                                else if (close_seen_reg && data_byte == CH_COLON &&
                                         {1'b0, pos_reg} == close_plus1)
                                begin
                                    colon_seen_next = 1'b1;
                                    colon_next      = pos_reg;
                                end
                            end
                            else if (data_byte == CH_COLON)
                            begin
                                colon_seen_next = 1'b1;
                                colon_next      = pos_reg;
                            end
                            end_next = pos_reg + ONE;
                        end
                    end
                    default:
                    begin
                    end
                endcase
            end
            pos_next = pos_reg + ONE;
        end
    end

    assign snap_valid              = step && end_of_request;
    assign snap_flags.is_long      = (phase_next == PH_LONG);
    assign snap_flags.is_done      = (phase_next == PH_DONE);
    assign snap_flags.text_seen    = text_seen_next;
    assign snap_flags.bracket_mode = bracket_next;
    assign snap_flags.close_seen   = close_seen_next;
    assign snap_flags.colon_seen   = colon_seen_next;
    assign first_pos               = first_next;
    assign end_pos                 = end_next;
    assign close_pos               = close_next;
    assign colon_pos               = colon_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg      <= PH_METHOD;
            pos_reg        <= '0;
            midx_reg       <= '0;
            prev_cr_reg    <= 1'b0;
            first_reg      <= '0;
            end_reg        <= '0;
            text_seen_reg  <= 1'b0;
            bracket_reg    <= 1'b0;
            close_reg      <= '0;
            close_seen_reg <= 1'b0;
            colon_reg      <= '0;
            colon_seen_reg <= 1'b0;
        end
        else if (step)
        begin
            if (end_of_request)
            begin
                phase_reg      <= PH_METHOD;
                pos_reg        <= '0;
                midx_reg       <= '0;
                prev_cr_reg    <= 1'b0;
                first_reg      <= '0;
                end_reg        <= '0;
                text_seen_reg  <= 1'b0;
                bracket_reg    <= 1'b0;
                close_reg      <= '0;
                close_seen_reg <= 1'b0;
                colon_reg      <= '0;
                colon_seen_reg <= 1'b0;
            end
            else
            begin
                phase_reg      <= phase_next;
                pos_reg        <= pos_next;
                midx_reg       <= midx_next;
                prev_cr_reg    <= prev_cr_next;
                first_reg      <= first_next;
                end_reg        <= end_next;
                text_seen_reg  <= text_seen_next;
                bracket_reg    <= bracket_next;
                close_reg      <= close_next;
                close_seen_reg <= close_seen_next;
                colon_reg      <= colon_next;
                colon_seen_reg <= colon_seen_next;
            end
        end
    end

endmodule

`default_nettype wire

FILE: rtl/clp_verdict.sv
// End-of-request snapshot register, host/port split and result register.
`timescale 1ns / 1ps
`default_nettype none

module clp_verdict
    import clp_pkg::*;
#(
    parameter int unsigned PW = 13
) (
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 snap_valid,
    output logic                      snap_ready,
    input  wire snap_flags_t          snap_flags,
    input  wire logic [PW-1:0]        first_pos,
    input  wire logic [PW-1:0]        end_pos,
    input  wire logic [PW-1:0]        close_pos,
    input  wire logic [PW-1:0]        colon_pos,
    output logic                      m_tvalid,
    input  wire logic                 m_tready,
    output logic [M_TDATA_W-1:0]      m_tdata
);

    localparam int unsigned CW = (PW + 1 > FIELD_W) ? PW + 1 : FIELD_W;
    localparam int unsigned PAD_W = M_TDATA_W - STATUS_W - 4 * FIELD_W;

    logic          sv_reg;
    snap_flags_t   flags_reg;
    logic [PW-1:0] first_reg, end_reg, close_reg, colon_reg;
    logic          snap_adv;

    logic                out_valid_reg;
    logic [STATUS_W-1:0] status_reg, status_next;
    logic [FIELD_W-1:0]  ho_reg, hl_reg, po_reg, pl_reg;
    logic [CW-1:0]       ho_next, hl_next, po_next, pl_next;

    logic [CW-1:0] fw, ew, cw, lw;

    assign fw = CW'(first_reg);
    assign ew = CW'(end_reg);
    assign cw = CW'(close_reg);
    assign lw = CW'(colon_reg);

    always_comb
    begin
        status_next = ST_MALFORMED;
        ho_next     = '0;
        hl_next     = '0;
        po_next     = '0;
        pl_next     = '0;
        if (flags_reg.is_long)
        begin
            status_next = ST_TOO_LONG;
        end
        else if (flags_reg.is_done && flags_reg.text_seen && flags_reg.colon_seen)
        begin
            if (flags_reg.bracket_mode)
            begin
                // host sits between the brackets, port after "]:"
                if (flags_reg.close_seen && cw > fw + CW'(1) && ew > cw + CW'(2))
                begin
                    status_next = ST_OK;
                    ho_next     = fw + CW'(1);
                    hl_next     = cw - fw - CW'(1);
                    po_next     = cw + CW'(2);
                    pl_next     = ew - cw - CW'(2);
                end
            end
            else if (lw > fw && ew > lw + CW'(1))
            begin
                status_next = ST_OK;
                ho_next     = fw;
                hl_next     = lw - fw;
                po_next     = lw + CW'(1);
                pl_next     = ew - lw - CW'(1);
            end
        end
    end

    assign snap_adv   = sv_reg && (!out_valid_reg || m_tready);
    assign snap_ready = !sv_reg || snap_adv;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sv_reg        <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (snap_valid)
                sv_reg <= 1'b1;
            else if (snap_adv)
                sv_reg <= 1'b0;

            if (snap_adv)
                out_valid_reg <= 1'b1;
            else if (m_tready)
                out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (snap_valid && snap_ready)
        begin
            flags_reg <= snap_flags;
            first_reg <= first_pos;
            end_reg   <= end_pos;
            close_reg <= close_pos;
            colon_reg <= colon_pos;
        end
        if (snap_adv)
        begin
            status_reg <= status_next;
            ho_reg     <= ho_next[FIELD_W-1:0];
            hl_reg     <= hl_next[FIELD_W-1:0];
            po_reg     <= po_next[FIELD_W-1:0];
            pl_reg     <= pl_next[FIELD_W-1:0];
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {{PAD_W{1'b0}}, pl_reg, po_reg, hl_reg, ho_reg, status_reg};

endmodule

`default_nettype wire

FILE: rtl/connect_request_line_parser.sv
// Top level of the CONNECT request line parser.
//
// Usage:
//   Request text enters on the s_ channel one byte per word; s_tlast marks the
//   final byte of a request. For every request one result word leaves on the
//   m_ channel: status, host offset/length and port offset/length within the
//   request. Offsets count from the first byte of the request.
//   Throughput: one byte per clock cycle, sustained while s_tready stays high,
//   set by the parser update behind the input register.
//   Path: the final byte of a request passes the input register, then the
//   end-of-request snapshot, then the result register, before its result
//   word is valid.
//   Reset: rst_n clears the parser to the start of a request and empties all
//   stages; no result is pending afterwards.
//   Stall: when m_tready is low the result holds; a second finished request
//   waits in the snapshot register, and bytes that do not end a request keep
//   flowing. Only a third request end backs up into s_tready.
`timescale 1ns / 1ps
`default_nettype none

module connect_request_line_parser
    import clp_pkg::*;
#(
    parameter int unsigned MAX_LEN = 4096
) (
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 s_tvalid,
    output logic                      s_tready,
    input  wire logic [S_TDATA_W-1:0] s_tdata,   // [7:0] data_byte
    input  wire logic                 s_tlast,   // end_of_request
    output logic                      m_tvalid,
    input  wire logic                 m_tready,
    output logic [M_TDATA_W-1:0]      m_tdata    // [1:0] status, [13:2] host_offset,
                                                 // [25:14] host_length,
                                                 // [37:26] port_offset,
                                                 // [49:38] port_length, [55:50] zero
);

    localparam int unsigned PW = $clog2(MAX_LEN + 1);

    logic              in_valid_reg;
    logic [BYTE_W-1:0] in_byte_reg;
    logic              in_last_reg;
    logic              step;
    logic              snap_valid;
    logic              snap_ready;
    snap_flags_t       snap_flags;
    logic [PW-1:0]     first_pos, end_pos, close_pos, colon_pos;

    // a request end can only move on when the snapshot slot frees up
    assign step     = in_valid_reg && (!in_last_reg || snap_ready);
    assign s_tready = !in_valid_reg || step;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            in_valid_reg <= 1'b0;
        else if (s_tready)
            in_valid_reg <= s_tvalid;
    end

    always_ff @(posedge clk)
    begin
        if (s_tvalid && s_tready)
        begin
            in_byte_reg <= s_tdata[BYTE_W-1:0];
            in_last_reg <= s_tlast;
        end
    end

    clp_parser #(
        .MAX_LEN (MAX_LEN),
        .PW      (PW)
    ) u_parser (
        .clk            (clk),
        .rst_n          (rst_n),
        .step           (step),
        .data_byte      (in_byte_reg),
        .end_of_request (in_last_reg),
        .snap_valid     (snap_valid),
        .snap_flags     (snap_flags),
        .first_pos      (first_pos),
        .end_pos        (end_pos),
        .close_pos      (close_pos),
        .colon_pos      (colon_pos)
    );

    clp_verdict #(
        .PW (PW)
    ) u_verdict (
        .clk        (clk),
        .rst_n      (rst_n),
        .snap_valid (snap_valid),
        .snap_ready (snap_ready),
        .snap_flags (snap_flags),
        .first_pos  (first_pos),
        .end_pos    (end_pos),
        .close_pos  (close_pos),
        .colon_pos  (colon_pos),
        .m_tvalid   (m_tvalid),
        .m_tready   (m_tready),
        .m_tdata    (m_tdata)
    );

endmodule

`default_nettype wire

FILE: rtl/clp_checker.sv
// Port-level assertions for the CONNECT request line parser, bound to the top.
`timescale 1ns / 1ps
`default_nettype none

module clp_checker
    import clp_pkg::*;
(
    input wire logic                 clk,
    input wire logic                 rst_n,
    input wire logic                 m_tvalid,
    input wire logic                 m_tready,
    input wire logic [M_TDATA_W-1:0] m_tdata
);

    // a stalled result word stays put
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("result word changed while stalled");

    a_status_code: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> (m_tdata[1:0] == ST_OK || m_tdata[1:0] == ST_MALFORMED ||
                      m_tdata[1:0] == ST_TOO_LONG))
        else $error("undefined status code");

    // rejected requests report no host or port
    a_reject_zero: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tdata[1:0] != ST_OK |-> m_tdata[49:2] == '0)
        else $error("rejected request carries host/port fields");

    a_pad_zero: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> m_tdata[55:50] == '0)
        else $error("padding bits not zero");

endmodule

bind connect_request_line_parser clp_checker u_clp_checker (
    .clk      (clk),
    .rst_n    (rst_n),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);

`default_nettype wire

FILE: tb/sv/tb.sv
// Self-checking testbench for the CONNECT request line parser.
`timescale 1ns / 1ps

module tb;
    import clp_pkg::*;

    localparam int unsigned REQ_LIMIT      = 4096;
    localparam int          WATCHDOG_LIMIT = 5000;
    localparam int          DRAIN_CYCLES   = 6;     // result path drain plus margin
    localparam int          RANDOM_BYTES   = 1600;

    localparam logic [63:0]       METHOD_WORD = "CONNECT ";
    localparam logic [BYTE_W-1:0] CH_VT = 8'h0B;
    localparam logic [BYTE_W-1:0] CH_FF = 8'h0C;

    typedef enum logic [2:0] {
        PH_METHOD, PH_AUTH, PH_AFTER, PH_DONE, PH_REJECT, PH_LONG
    } phase_t;

    typedef struct packed {
        logic [STATUS_W-1:0] status;
        logic [FIELD_W-1:0]  host_off;
        logic [FIELD_W-1:0]  host_len;
        logic [FIELD_W-1:0]  port_off;
        logic [FIELD_W-1:0]  port_len;
    } line_result_t;

    logic                 clk = 1'b0;
    logic                 rst_n = 1'b0;
    logic                 s_tvalid = 1'b0;
    logic                 s_tready;
    logic [S_TDATA_W-1:0] s_tdata = '0;
    logic                 s_tlast = 1'b0;
    logic                 m_tvalid;
    logic                 m_tready = 1'b0;
    logic [M_TDATA_W-1:0] m_tdata;

    connect_request_line_parser #(
        .MAX_LEN(REQ_LIMIT)
    ) dut (
        .clk(clk),
        .rst_n(rst_n),
        .s_tvalid(s_tvalid),
        .s_tready(s_tready),
        .s_tdata(s_tdata),
        .s_tlast(s_tlast),
        .m_tvalid(m_tvalid),
        .m_tready(m_tready),
        .m_tdata(m_tdata)
    );

    always #5 clk = ~clk;

    // parser state as the block should hold it
    logic [12:0] rq_pos;
    phase_t      rq_phase;
    logic [3:0]  rq_match;
    logic        rq_cr;
    logic [12:0] txt_first;
    logic [12:0] txt_end;
    logic        txt_seen;
    logic        brk_mode;
    logic [12:0] rbrk_pos;
    logic        rbrk_seen;
    logic [12:0] colon_pos;
    logic        colon_found;

    line_result_t pending_results[$];
    logic [7:0]   req_bytes[$];

    int errors = 0;
    int results_seen = 0;
    int n_ok = 0;
    int n_malformed = 0;
    int n_long = 0;
    int requests_sent = 0;
    int bytes_sent = 0;
    int line_len = 0;
    int quiet_cycles = 0;
    bit tx_free = 1'b0;
    bit rx_free = 1'b0;
    int hold_req = 0;
    int rx_hold = 0;
    int rx_run = 0;

    function automatic bit is_ws(input logic [7:0] b);
        return (b == CH_SPACE) || ((b >= CH_TAB) && (b <= CH_CR));
    endfunction

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 60)
            return 0;
        else if (r < 90)
            return $urandom_range(1, 3);
        else if (r < 97)
            return $urandom_range(4, 12);
        else
            return $urandom_range(20, 80);
    endfunction

    function automatic logic [7:0] pick_ws();
        case ($urandom_range(0, 4))
            0:       return CH_TAB;
            1:       return CH_LF;
            2:       return CH_VT;
            3:       return CH_FF;
            default: return CH_CR;
        endcase
    endfunction

    task automatic clear_request();
        rq_pos      = '0;
        rq_phase    = PH_METHOD;
        rq_match    = '0;
        rq_cr       = 1'b0;
        txt_first   = '0;
        txt_end     = '0;
        txt_seen    = 1'b0;
        brk_mode    = 1'b0;
        rbrk_pos    = '0;
        rbrk_seen   = 1'b0;
        colon_pos   = '0;
        colon_found = 1'b0;
    endtask

    task automatic authority_byte(input logic [7:0] b, input logic [12:0] p);
        if (b == CH_SPACE)
        begin
            rq_phase = PH_AFTER;
        end
        else if (!is_ws(b))
        begin
            if (!txt_seen)
            begin
                txt_seen  = 1'b1;
                txt_first = p;
                brk_mode  = (b == CH_LBRK);
                if (!brk_mode && b == CH_COLON)
                begin
                    colon_found = 1'b1;
                    colon_pos   = p;
                end
            end
            else if (brk_mode)
            begin
                if (b == CH_RBRK && !rbrk_seen)
                begin
                    rbrk_seen = 1'b1;
                    rbrk_pos  = p;
                end
                else if (rbrk_seen && b == CH_COLON && p == rbrk_pos + 13'd1)
                begin
                    // only a colon right behind the bracket counts
                    colon_found = 1'b1;
                    colon_pos   = p;
                end
            end
            else if (b == CH_COLON)
            begin
                colon_found = 1'b1;
                colon_pos   = p;
            end
            txt_end = p + 13'd1;
        end
    endtask

    function automatic line_result_t line_verdict();
        line_result_t r;
        int unsigned  first;
        int unsigned  stop;
        int unsigned  rb;
        int unsigned  cp;
        first = 32'(txt_first);
        stop  = 32'(txt_end);
        rb    = 32'(rbrk_pos);
        cp    = 32'(colon_pos);
        r     = '0;
        r.status = ST_MALFORMED;
        if (rq_phase == PH_LONG)
        begin
            r.status = ST_TOO_LONG;
        end
        else if (rq_phase == PH_DONE && txt_seen && colon_found)
        begin
            if (brk_mode)
            begin
                if (rbrk_seen && rb > first + 1 && stop > rb + 2)
                begin
                    r.status   = ST_OK;
                    r.host_off = FIELD_W'(first + 1);
                    r.host_len = FIELD_W'(rb - first - 1);
                    r.port_off = FIELD_W'(rb + 2);
                    r.port_len = FIELD_W'(stop - rb - 2);
                end
            end
            else if (cp > first && stop > cp + 1)
            begin
                r.status   = ST_OK;
                r.host_off = FIELD_W'(first);
                r.host_len = FIELD_W'(cp - first);
                r.port_off = FIELD_W'(cp + 1);
                r.port_len = FIELD_W'(stop - cp - 1);
            end
        end
        return r;
    endfunction

    task automatic track_byte(input logic [7:0] b, input logic last);
        logic [12:0] p;
        p = rq_pos;
        if (rq_phase != PH_LONG && p >= REQ_LIMIT)
        begin
            rq_phase = PH_LONG;
        end
        else if (rq_phase != PH_LONG)
        begin
            if (rq_cr && b == CH_LF && rq_phase <= PH_AFTER)
            begin
                if (rq_phase == PH_AFTER)
                    rq_phase = PH_DONE;
                else
                    rq_phase = PH_REJECT;
            end
            else if (rq_phase == PH_METHOD)
            begin
                if (rq_match < 4'd8 && b == METHOD_WORD[63 - 8 * rq_match[2:0] -: 8])
                begin
                    rq_match = rq_match + 4'd1;
                    if (rq_match == 4'd8)
                        rq_phase = PH_AUTH;
                end
                else
                begin
                    rq_phase = PH_REJECT;
                end
            end
            else if (rq_phase == PH_AUTH)
            begin
                authority_byte(b, p);
            end
            rq_pos = p + 13'd1;
        end
        rq_cr = (b == CH_CR);
        if (last)
        begin
            pending_results.push_back(line_verdict());
            clear_request();
        end
    endtask

    task automatic report_mismatch(input string what, input int unsigned want,
                                   input int unsigned got);
        $display("ERROR at %0t: %s expected %0d got %0d", $time, what, want, got);
        errors++;
    endtask

    // result checker
    always @(posedge clk)
    begin
        line_result_t want;
        if (rst_n && m_tvalid && m_tready)
        begin
            if (pending_results.size() == 0)
            begin
                report_mismatch("result word with none pending, status", 0,
                                32'(m_tdata[1:0]));
            end
            else
            begin
                want = pending_results.pop_front();
                results_seen++;
                if (want.status == ST_OK)
                    n_ok++;
                else if (want.status == ST_TOO_LONG)
                    n_long++;
                else
                    n_malformed++;
                if (m_tdata[1:0] != want.status)
                    report_mismatch("status", 32'(want.status), 32'(m_tdata[1:0]));
                if (m_tdata[13:2] != want.host_off)
                    report_mismatch("host_offset", 32'(want.host_off), 32'(m_tdata[13:2]));
                if (m_tdata[25:14] != want.host_len)
                    report_mismatch("host_length", 32'(want.host_len), 32'(m_tdata[25:14]));
                if (m_tdata[37:26] != want.port_off)
                    report_mismatch("port_offset", 32'(want.port_off), 32'(m_tdata[37:26]));
                if (m_tdata[49:38] != want.port_len)
                    report_mismatch("port_length", 32'(want.port_len), 32'(m_tdata[49:38]));
                if (m_tdata[55:50] != '0)
                    report_mismatch("pad bits", 0, 32'(m_tdata[55:50]));
            end
        end
    end

    // result receiver: random ready pattern, always ready when rx_free is set, or a long hold when asked
    always @(negedge clk)
    begin
        if (hold_req > 0)
        begin
            rx_hold  = hold_req;
            hold_req = 0;
        end
        if (rx_hold > 0)
        begin
            rx_hold--;
            m_tready <= 1'b0;
        end
        else if (rx_free)
        begin
            m_tready <= 1'b1;
        end
        else if (rx_run > 0)
        begin
            rx_run--;
        end
        else
        begin
            m_tready <= ($urandom_range(0, 3) != 0);
            rx_run = pick_gap();
        end
    end

    always @(posedge clk)
    begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
            quiet_cycles = 0;
        else
            quiet_cycles++;
        if (quiet_cycles >= WATCHDOG_LIMIT)
        begin
            $display("timeout: no word moved for %0d cycles", WATCHDOG_LIMIT);
            $display("connect_request_line_parser: mismatch");
            $finish;
        end
    end

    // called at a falling edge; returns at the falling edge after the word is taken
    task automatic send_byte(input logic [7:0] b, input logic last);
        int gap;
        gap = tx_free ? 0 : pick_gap();
        if (gap > 0)
        begin
            s_tvalid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= b;
        s_tlast  <= last;
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
        track_byte(b, last);
        bytes_sent++;
        @(negedge clk);
    endtask

    task automatic push_byte(input logic [7:0] b);
        req_bytes.push_back(b);
    endtask

    task automatic push_text(input string s);
        for (int i = 0; i < s.len(); i++)
            req_bytes.push_back(s[i]);
    endtask

    task automatic push_crlf();
        push_byte(CH_CR);
        push_byte(CH_LF);
    endtask

    // n characters from set, now and then a fully random byte
    task automatic push_from(input string set, input int n);
        repeat (n)
        begin
            if ($urandom_range(0, 19) == 0)
                push_byte(8'($urandom_range(0, 255)));
            else
                push_byte(set[$urandom_range(0, set.len() - 1)]);
        end
    endtask

    task automatic send_request();
        if (req_bytes.size() == 0)
            push_byte(8'($urandom_range(0, 255)));
        for (int i = 0; i < req_bytes.size(); i++)
            send_byte(req_bytes[i], i == req_bytes.size() - 1);
        req_bytes.delete();
        requests_sent++;
    endtask

    task automatic connect_line(input string auth);
        push_text("CONNECT ");
        push_text(auth);
        push_text(" HTTP/1.1");
        push_crlf();
        send_request();
    endtask

    task automatic wait_idle();
        s_tvalid <= 1'b0;
        while (pending_results.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        @(negedge clk);
    endtask

    task automatic test_well_formed();
        connect_line("example.com:443");
        connect_line("[2001:db8::1]:8080");
        connect_line("a:1");
        // trimmed whitespace on both ends, stray CR at the tail
        push_text("CONNECT ");
        push_byte(CH_TAB);
        push_byte(CH_VT);
        push_text("h:22");
        push_byte(CH_FF);
        push_byte(CH_CR);
        push_text(" x");
        push_crlf();
        send_request();
        push_text("CONNECT ");
        push_byte(8'hFF);
        push_text(":9 ");
        push_byte(8'h00);
        push_crlf();
        send_request();
    endtask

    task automatic test_method();
        push_text("GET / HTTP/1.1");
        push_crlf();
        send_request();
        push_text("connect h:1 x");
        push_crlf();
        send_request();
        push_text("CONNECT  h:1 x");   // empty authority
        push_crlf();
        send_request();
        push_text("CONNEC");
        push_crlf();
        send_request();
        push_byte(8'h00);
        send_request();
        push_byte(8'hFF);
        send_request();
    endtask

    task automatic test_authority();
        connect_line("h:");
        connect_line(":80");
        connect_line("hostonly");
        connect_line("a:b:c:1");
        connect_line("[::1");
        connect_line("[]:80");
        connect_line("[::1]80");
        connect_line("[::1]x:80");
        connect_line("[::1]:");
        connect_line("[a]b]:1");
        connect_line("[v6]:8:9");
    endtask

    task automatic test_line_end();
        push_text("CONNECT h:1 x");     // never reaches CR LF
        send_request();
        push_text("CONNECT h:1");       // CR LF before the closing space
        push_crlf();
        send_request();
        push_text("CONNECT h:1");       // lone CR inside the authority
        push_byte(CH_CR);
        push_text("2 x");
        push_crlf();
        send_request();
        push_text("CONNECT h:1 x");     // junk after the line is ignored
        push_crlf();
        push_text("[q]:5 ");
        push_crlf();
        push_byte(8'hFF);
        send_request();
    endtask

    task automatic test_long();
        // exactly REQ_LIMIT bytes, host near the top of the offset range
        push_text("CONNECT ");
        repeat (4080) push_byte(CH_TAB);
        push_text("hh:99 ");
        push_crlf();
        send_request();
        // one byte more tips it into the too-long case
        push_text("CONNECT ");
        repeat (4080) push_byte(CH_TAB);
        push_text("hh:99 ");
        push_crlf();
        push_byte(8'h41);
        send_request();
        repeat (4300) push_byte(8'($urandom_range(0, 255)));
        send_request();
    endtask

    task automatic test_pressure();
        wait_idle();
        hold_req = 400;
        tx_free  = 1'b1;
        for (int i = 0; i < 40; i++)
        begin
            if (i % 5 == 4)
            begin
                connect_line("p:1");
            end
            else
            begin
                push_from("abcdefghijklmnopqrstuvwxyz0123456789", $urandom_range(1, 3));
                send_request();
            end
        end
        tx_free = 1'b0;
        wait_idle();
    endtask

    task automatic build_random_request();
        int k;
        int r;
        bit cut;
        req_bytes.delete();
        if ($urandom_range(0, 99) < 8)
        begin
            push_from("CONNECT []: abc123", $urandom_range(1, 24));
            for (int i = 0; i < req_bytes.size(); i++)
                if ($urandom_range(0, 3) == 0)
                    req_bytes[i] = 8'($urandom_range(0, 255));
            line_len = req_bytes.size();
        end
        else
        begin
            if ($urandom_range(0, 9) != 0)
            begin
                push_text("CONNECT ");
            end
            else
            begin
                k   = $urandom_range(0, 7);
                cut = ($urandom_range(0, 3) == 0);
                for (int i = 0; i < 8; i++)
                begin
                    if (cut && i == k)
                        break;
                    if (i == k)
                        push_byte(8'($urandom_range(0, 255)));
                    else
                        push_byte(METHOD_WORD[63 - 8 * i -: 8]);
                end
            end
            if ($urandom_range(0, 2) == 0)
                repeat ($urandom_range(1, 3)) push_byte(pick_ws());
            r = $urandom_range(0, 99);
            if (r < 55)
            begin
                if ($urandom_range(0, 9) != 0)
                    push_from("abcdefghijklmnopqrstuvwxyz0123456789.-", $urandom_range(1, 12));
                if ($urandom_range(0, 9) == 0)
                begin
                    push_byte(CH_COLON);
                    push_from("abc.-", $urandom_range(1, 3));
                end
                if ($urandom_range(0, 19) != 0)
                    push_byte(CH_COLON);
                if ($urandom_range(0, 9) != 0)
                    push_from("0123456789", $urandom_range(1, 5));
            end
            else if (r < 90)
            begin
                push_byte(CH_LBRK);
                push_from("0123456789abcdef:", $urandom_range(0, 10));
                if ($urandom_range(0, 9) != 0)
                    push_byte(CH_RBRK);
                k = $urandom_range(0, 9);
                if (k < 8)
                begin
                    if (k == 7)
                        push_from("x]z", $urandom_range(1, 2));
                    push_byte(CH_COLON);
                    if (k != 6)
                        push_from("0123456789", $urandom_range(1, 5));
                end
                else
                begin
                    push_from("0123456789", $urandom_range(0, 3));
                end
            end
            else
            begin
                push_from("[]:ab1.", $urandom_range(0, 10));
            end
            if ($urandom_range(0, 3) == 0)
                repeat ($urandom_range(1, 2)) push_byte(pick_ws());
            r = $urandom_range(0, 99);
            if (r < 80)
            begin
                push_text(" HTTP/1.1");
                push_crlf();
            end
            else if (r < 86)
            begin
                push_crlf();
            end
            else if (r < 92)
            begin
                push_text(" HTTP");
            end
            else if (r < 96)
            begin
                push_byte(CH_CR);
                push_byte(8'($urandom_range(0, 255)));
            end
            else
            begin
                push_byte(CH_SPACE);
                push_byte(CH_CR);
                push_crlf();
            end
            line_len = req_bytes.size();
            if ($urandom_range(0, 3) == 0)
                push_from("Host: a:1", $urandom_range(1, 6));
        end
    endtask

    task automatic test_random();
        int counted;
        counted = 0;
        while (counted < RANDOM_BYTES)
        begin
            if (requests_sent % 20 == 0)
                rx_free = ($urandom_range(0, 3) == 0);
            tx_free = ($urandom_range(0, 9) == 0);
            build_random_request();
            counted += line_len;
            send_request();
        end
        tx_free = 1'b0;
        rx_free = 1'b0;
    endtask

    initial
    begin
        clear_request();
        repeat (2) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);
        test_well_formed();
        test_method();
        test_authority();
        test_line_end();
        test_long();
        test_pressure();
        test_random();
        wait_idle();
        $display("sent %0d requests (%0d bytes), checked %0d result words", requests_sent,
                 bytes_sent, results_seen);
        $display("verdicts: %0d accepted, %0d malformed, %0d too long, %0d errors", n_ok,
                 n_malformed, n_long, errors);
        if (errors == 0)
            $display("connect_request_line_parser: match");
        else
            $display("connect_request_line_parser: mismatch");
        $finish;
    end

endmodule

FILE: sim.f
rtl/clp_pkg.sv
rtl/clp_parser.sv
rtl/clp_verdict.sv
rtl/connect_request_line_parser.sv
rtl/clp_checker.sv
tb/sv/tb.sv
